@@ rtl/core/smoothed_lattice_ladder_filter_core_macros.svh @@
// assertion macros for the smoothed lattice-ladder filter core
// no dependencies; taken in by the rtl files that carry assertions
`ifndef SMOOTHED_LATTICE_LADDER_FILTER_CORE_MACROS_SVH
`define SMOOTHED_LATTICE_LADDER_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SLLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define SLLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/slld_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, operation codes and control structs of the filter core
// no dependencies; imported by every module of the core

package slld_pkg;

  // default widths
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned COEFF_WIDTH_DEF  = 32;

  // fixed formats
  localparam int unsigned LAT_W       = 40;
  localparam int unsigned SMOOTH_W    = 29;
  localparam int unsigned SMOOTH_FRAC = 28;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REFL_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFL_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ZERO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH      = 3'd5;

  // operations run through the shared multiplier, in order
  localparam int unsigned OP_W = 4;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_GK0  = 4'd0;   // glide first reflection coefficient
  localparam op_t OP_GK1  = 4'd1;   // glide second reflection coefficient
  localparam op_t OP_GV0  = 4'd2;   // glide ladder weights
  localparam op_t OP_GV1  = 4'd3;
  localparam op_t OP_GV2  = 4'd4;
  localparam op_t OP_F1   = 4'd5;   // f1 = x - k1*g1
  localparam op_t OP_F0   = 4'd6;   // f0 = f1 - k0*g0
  localparam op_t OP_G2   = 4'd7;   // g2 = g1 + k1*f1
  localparam op_t OP_G1   = 4'd8;   // g1 = g0 + k0*f0, g0 = f0
  localparam op_t OP_Y0   = 4'd9;   // ladder sum terms
  localparam op_t OP_Y1   = 4'd10;
  localparam op_t OP_Y2   = 4'd11;
  localparam op_t OP_LAST = OP_Y2;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic mul0;
    logic mul1;
    logic fin;
    logic out_load;
    op_t  op;
  } seq_ctrl_t;

  // multiplier control
  typedef struct packed {
    logic load;
    logic first;
    logic second;
    logic coeff_shift;
  } mul_ctrl_t;

endpackage

@@ rtl/core/slld_mul.sv @@
`timescale 1ns / 1ps
// shared sign-magnitude multiplier: two partial-product passes, rounding shift
// depends on slld_pkg

module slld_mul import slld_pkg::*; #(
  parameter int unsigned A_W      = COEFF_WIDTH_DEF + 1,
  parameter int unsigned B_W      = LAT_W,
  parameter int unsigned SH_COEFF = COEFF_WIDTH_DEF - 4,
  parameter int unsigned Q_W      = 44
) (
  input  logic           clk_i,
  input  mul_ctrl_t      ctrl_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  input  logic           neg_i,
  output logic [Q_W-1:0] q_o,
  output logic           neg_o
);

  localparam int unsigned LO_W = B_W / 2;
  localparam int unsigned HI_W = B_W - LO_W;
  localparam int unsigned PP_W = A_W + HI_W;
  localparam int unsigned P_W  = A_W + B_W;
  localparam logic [P_W-1:0] RND_COEFF  = P_W'(1) << (SH_COEFF - 1);
  localparam logic [P_W-1:0] RND_SMOOTH = P_W'(1) << (SMOOTH_FRAC - 1);

  logic [A_W-1:0]  a_q;
  logic [B_W-1:0]  b_q;
  logic            neg_q;
  logic            shc_q;
  logic [P_W-1:0]  acc_q, acc_d;
  logic [HI_W-1:0] b_part;
  logic [PP_W-1:0] pp;
  logic [P_W-1:0]  shifted;

  // operand capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q   <= a_i;
      b_q   <= b_i;
      neg_q <= neg_i;
      shc_q <= ctrl_i.coeff_shift;
    end
  end

  // one multiplier, low half of b first, then the high half
  always_comb begin
    b_part = ctrl_i.first ? HI_W'(b_q[LO_W-1:0]) : b_q[B_W-1:LO_W];
    pp     = {{HI_W{1'b0}}, a_q} * {{A_W{1'b0}}, b_part};
  end

  // accumulate, the rounding half is folded in on the first pass
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.first) begin
      acc_d = {{LO_W{1'b0}}, pp} + (shc_q ? RND_COEFF : RND_SMOOTH);
    end else if (ctrl_i.second) begin
      acc_d = acc_q + {pp, {LO_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // drop the fraction bits
  always_comb begin
    shifted = shc_q ? (acc_q >> SH_COEFF) : (acc_q >> SMOOTH_FRAC);
    q_o     = shifted[Q_W-1:0];
    neg_o   = neg_q;
  end

endmodule

@@ rtl/core/slld_seq.sv @@
`timescale 1ns / 1ps
// sequencer: steps the twelve products through load, two passes and finish
// depends on slld_pkg

module slld_seq import slld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  output logic      in_ready_o,
  output seq_ctrl_t ctrl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MUL0  = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0] state_q, state_d;
  op_t        op_q, op_d;

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOAD;
          op_d    = OP_GK0;
        end
      end
      S_LOAD: begin
        state_d = S_MUL0;
      end
      S_MUL0: begin
        state_d = S_MUL1;
      end
      S_MUL1: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (op_q == OP_LAST) begin
          state_d = S_DRAIN;
        end else begin
          state_d = S_LOAD;
          op_d    = op_t'(op_q + 1'b1);
        end
      end
      S_DRAIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_GK0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // strobes
  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    ctrl_o.accept   = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.load     = (state_q == S_LOAD);
    ctrl_o.mul0     = (state_q == S_MUL0);
    ctrl_o.mul1     = (state_q == S_MUL1);
    ctrl_o.fin      = (state_q == S_FIN);
    ctrl_o.out_load = (state_q == S_DRAIN) && out_free_i;
    ctrl_o.op       = op_q;
  end

endmodule

@@ rtl/core/smoothed_lattice_ladder_filter_core.sv @@
`timescale 1ns / 1ps
// top level of the smoothed second-order lattice-ladder filter core
// depends on slld_pkg, slld_mul, slld_seq and the core macro header
//
//  channel  handshake                 payload
//  in       in_valid_i / in_ready_o   sample_in_i, snap_i
//  out      out_valid_o / out_ready_i sample_out_o
//  cfg      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// each item runs twelve products (five coefficient glides, four lattice products,
// three ladder terms) one after another through the one shared multiplier, each as
// operand load, two partial-product passes, round and combine, plus accept and hand-off
// in_ready_o is high only while idle; a result waits in the output register
// a stalled output holds the core in its hand-off state until the register frees
// reset: coefficients to unity gain, lattice states to zero, no item in flight

`include "smoothed_lattice_ladder_filter_core_macros.svh"

module smoothed_lattice_ladder_filter_core import slld_pkg::*; #(
  parameter  int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter  int unsigned COEFF_WIDTH  = COEFF_WIDTH_DEF,
  localparam int unsigned CFG_DW = (COEFF_WIDTH > SMOOTH_W) ? COEFF_WIDTH : SMOOTH_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           snap_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_DW-1:0]              cfg_wdata_i
);

  localparam int unsigned CW   = COEFF_WIDTH;
  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned FRAC = CW - 4;
  localparam int unsigned DW   = (CW + 2 > 46) ? CW + 2 : 46;
  localparam int unsigned QW   = (CW + 1 > 43) ? CW + 1 : 43;
  localparam logic signed [CW-1:0] ONE_COEFF = CW'(1) << FRAC;
  localparam logic [SMOOTH_W-1:0]  ONE_SF    = SMOOTH_W'(1) << SMOOTH_FRAC;
  localparam logic signed [DW-1:0] LAT_MAX =
    signed'({{(DW-LAT_W+1){1'b0}}, {(LAT_W-1){1'b1}}});
  localparam logic signed [DW-1:0] LAT_MIN =
    signed'({{(DW-LAT_W+1){1'b1}}, {(LAT_W-1){1'b0}}});
  localparam logic signed [DW-1:0] OUT_MAX =
    signed'({{(DW-SW+1){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [DW-1:0] OUT_MIN =
    signed'({{(DW-SW+1){1'b1}}, {(SW-1){1'b0}}});

  // target registers and smoothing factor
  logic signed [CW-1:0] tgt_k0_q, tgt_k1_q, tgt_v0_q, tgt_v1_q, tgt_v2_q;
  logic [SMOOTH_W-1:0]  sf_q;

  // current coefficients and lattice state
  logic signed [CW-1:0]    cur_k0_q, cur_k1_q, cur_v0_q, cur_v1_q, cur_v2_q;
  logic signed [LAT_W-1:0] g0_q, g1_q, g2_q;
  logic signed [LAT_W-1:0] x_q, f0_q, f1_q;
  logic signed [DW-1:0]    acc_q;

  // output register
  logic                 out_valid_q;
  logic signed [SW-1:0] out_data_q;
  logic                 out_free;

  seq_ctrl_t ctrl;
  mul_ctrl_t mctrl;

  logic signed [CW:0]      coef_sel;
  logic signed [LAT_W-1:0] st_sel;
  logic                    is_glide;
  logic [SMOOTH_W-1:0]     sf_eff;
  logic [CW:0]             a_mag;
  logic [LAT_W-1:0]        b_mag;
  logic                    op_neg;
  logic [QW-1:0]           q;
  logic                    q_neg;
  logic signed [DW-1:0]    base_s, q_s, r_s;
  logic                    is_sub;
  logic [LAT_W-1:0]        r_lat;
  logic [SW-1:0]           out_sat;

  // target minus current, one bit wider
  function automatic logic signed [CW:0] diff_f(input logic signed [CW-1:0] t,
                                                input logic signed [CW-1:0] c);
    diff_f = (CW+1)'(t) - (CW+1)'(c);
  endfunction

  slld_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_k0_q <= '0;
      tgt_k1_q <= '0;
      tgt_v0_q <= ONE_COEFF;
      tgt_v1_q <= '0;
      tgt_v2_q <= '0;
      sf_q     <= ONE_SF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REFL_FIRST:  tgt_k0_q <= cfg_wdata_i[CW-1:0];
        REG_REFL_SECOND: tgt_k1_q <= cfg_wdata_i[CW-1:0];
        REG_TAP_ZERO:    tgt_v0_q <= cfg_wdata_i[CW-1:0];
        REG_TAP_ONE:     tgt_v1_q <= cfg_wdata_i[CW-1:0];
        REG_TAP_TWO:     tgt_v2_q <= cfg_wdata_i[CW-1:0];
        REG_SMOOTH:      sf_q     <= cfg_wdata_i[SMOOTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // operand selection for the next product
  always_comb begin
    sf_eff   = (sf_q > ONE_SF) ? ONE_SF : sf_q;
    coef_sel = '0;
    st_sel   = '0;
    is_glide = 1'b0;
    unique case (ctrl.op)
      OP_GK0: begin
        coef_sel = diff_f(tgt_k0_q, cur_k0_q);
        st_sel   = signed'(LAT_W'(sf_eff));
        is_glide = 1'b1;
      end
      OP_GK1: begin
        coef_sel = diff_f(tgt_k1_q, cur_k1_q);
        st_sel   = signed'(LAT_W'(sf_eff));
        is_glide = 1'b1;
      end
      OP_GV0: begin
        coef_sel = diff_f(tgt_v0_q, cur_v0_q);
        st_sel   = signed'(LAT_W'(sf_eff));
        is_glide = 1'b1;
      end
      OP_GV1: begin
        coef_sel = diff_f(tgt_v1_q, cur_v1_q);
        st_sel   = signed'(LAT_W'(sf_eff));
        is_glide = 1'b1;
      end
      OP_GV2: begin
        coef_sel = diff_f(tgt_v2_q, cur_v2_q);
        st_sel   = signed'(LAT_W'(sf_eff));
        is_glide = 1'b1;
      end
      OP_F1: begin
        coef_sel = (CW+1)'(cur_k1_q);
        st_sel   = g1_q;
      end
      OP_F0: begin
        coef_sel = (CW+1)'(cur_k0_q);
        st_sel   = g0_q;
      end
      OP_G2: begin
        coef_sel = (CW+1)'(cur_k1_q);
        st_sel   = f1_q;
      end
      OP_G1: begin
        coef_sel = (CW+1)'(cur_k0_q);
        st_sel   = f0_q;
      end
      OP_Y0: begin
        coef_sel = (CW+1)'(cur_v0_q);
        st_sel   = g0_q;
      end
      OP_Y1: begin
        coef_sel = (CW+1)'(cur_v1_q);
        st_sel   = g1_q;
      end
      OP_Y2: begin
        coef_sel = (CW+1)'(cur_v2_q);
        st_sel   = g2_q;
      end
      default: begin
      end
    endcase
    a_mag  = coef_sel[CW] ? unsigned'(-coef_sel) : unsigned'(coef_sel);
    b_mag  = st_sel[LAT_W-1] ? unsigned'(-st_sel) : unsigned'(st_sel);
    op_neg = coef_sel[CW] ^ st_sel[LAT_W-1];
  end

  always_comb begin
    mctrl.load        = ctrl.load;
    mctrl.first       = ctrl.mul0;
    mctrl.second      = ctrl.mul1;
    mctrl.coeff_shift = !is_glide;
  end

  slld_mul #(
    .A_W      (CW + 1),
    .B_W      (LAT_W),
    .SH_COEFF (FRAC),
    .Q_W      (QW)
  ) u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mctrl),
    .a_i    (a_mag),
    .b_i    (b_mag),
    .neg_i  (op_neg),
    .q_o    (q),
    .neg_o  (q_neg)
  );

  // combine the rounded product with its base value
  always_comb begin
    base_s = '0;
    is_sub = 1'b0;
    unique case (ctrl.op)
      OP_GK0:  base_s = DW'(cur_k0_q);
      OP_GK1:  base_s = DW'(cur_k1_q);
      OP_GV0:  base_s = DW'(cur_v0_q);
      OP_GV1:  base_s = DW'(cur_v1_q);
      OP_GV2:  base_s = DW'(cur_v2_q);
      OP_F1: begin
        base_s = DW'(x_q);
        is_sub = 1'b1;
      end
      OP_F0: begin
        base_s = DW'(f1_q);
        is_sub = 1'b1;
      end
      OP_G2:   base_s = DW'(g1_q);
      OP_G1:   base_s = DW'(g0_q);
      OP_Y0:   base_s = '0;
      OP_Y1:   base_s = acc_q;
      OP_Y2:   base_s = acc_q;
      default: base_s = '0;
    endcase
    q_s = signed'({{(DW-QW){1'b0}}, q});
    r_s = (q_neg ^ is_sub) ? (base_s - q_s) : (base_s + q_s);
    if (r_s > LAT_MAX) begin
      r_lat = LAT_MAX[LAT_W-1:0];
    end else if (r_s < LAT_MIN) begin
      r_lat = LAT_MIN[LAT_W-1:0];
    end else begin
      r_lat = r_s[LAT_W-1:0];
    end
  end

  // coefficients: snap on accept, glide on finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_k0_q <= '0;
      cur_k1_q <= '0;
      cur_v0_q <= ONE_COEFF;
      cur_v1_q <= '0;
      cur_v2_q <= '0;
    end else if (ctrl.accept && snap_i) begin
      cur_k0_q <= tgt_k0_q;
      cur_k1_q <= tgt_k1_q;
      cur_v0_q <= tgt_v0_q;
      cur_v1_q <= tgt_v1_q;
      cur_v2_q <= tgt_v2_q;
    end else if (ctrl.fin) begin
      if (ctrl.op == OP_GK0) cur_k0_q <= r_s[CW-1:0];
      if (ctrl.op == OP_GK1) cur_k1_q <= r_s[CW-1:0];
      if (ctrl.op == OP_GV0) cur_v0_q <= r_s[CW-1:0];
      if (ctrl.op == OP_GV1) cur_v1_q <= r_s[CW-1:0];
      if (ctrl.op == OP_GV2) cur_v2_q <= r_s[CW-1:0];
    end
  end

  // lattice state, saturated to the state width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g0_q <= '0;
      g1_q <= '0;
      g2_q <= '0;
    end else if (ctrl.fin) begin
      if (ctrl.op == OP_G2) begin
        g2_q <= r_lat;
      end
      if (ctrl.op == OP_G1) begin
        g1_q <= r_lat;
        g0_q <= f0_q;
      end
    end
  end

  // per-item working values
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      x_q <= LAT_W'(sample_in_i);
    end
    if (ctrl.fin && ctrl.op == OP_F1) begin
      f1_q <= r_lat;
    end
    if (ctrl.fin && ctrl.op == OP_F0) begin
      f0_q <= r_lat;
    end
    if (ctrl.fin && (ctrl.op == OP_Y0 || ctrl.op == OP_Y1 || ctrl.op == OP_Y2)) begin
      acc_q <= r_s;
    end
  end

  // output saturation and register
  always_comb begin
    if (acc_q > OUT_MAX) begin
      out_sat = OUT_MAX[SW-1:0];
    end else if (acc_q < OUT_MIN) begin
      out_sat = OUT_MIN[SW-1:0];
    end else begin
      out_sat = acc_q[SW-1:0];
    end
    out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= out_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  // checks
  `SLLD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "core still ready after taking an item")
  `SLLD_ASSERT_IMP(a_idle_on_result, clk_i, rst_ni, $rose(out_valid_o), in_ready_o, "result shown while core not idle")
  `SLLD_ASSERT_NXT(a_snap_copies, clk_i, rst_ni, ctrl.accept && snap_i, cur_k0_q == $past(tgt_k0_q) && cur_v2_q == $past(tgt_v2_q), "snap did not copy targets")
  `SLLD_ASSERT_NXT(a_full_glide, clk_i, rst_ni, ctrl.fin && ctrl.op == OP_GK0 && sf_q >= ONE_SF, cur_k0_q == $past(tgt_k0_q), "full smoothing missed its target")

endmodule
